// ===== sv/ozmd_pkg.sv =====
// Shared types and constants for the optical-flow zero-motion detector.
// No dependencies; imported by every module of the block.
package ozmd_pkg;

  // Field widths
  localparam int unsigned FLOW_W   = 16;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned RATE_W   = 10;
  localparam int unsigned FOCAL_W  = 13;
  localparam int unsigned FSUM_W   = FOCAL_W + 1;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned SUM_W    = 26;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Square sum and root widths
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned ROOT_W   = SQ_W / 2;
  localparam int unsigned ROOT_CNT_W = $clog2(ROOT_W);

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_A_W  = SUM_W;
  localparam int unsigned MUL_B_W  = 16;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;

  // Decision compare widths
  localparam int unsigned LHS_W    = SUM_W + FSUM_W;
  localparam int unsigned GRATE_W  = GAIN_W + RATE_W;
  localparam int unsigned RHS_W    = GRATE_W + CNT_W + 4;

  // Limits
  localparam int unsigned MAX_FEATURES = 1024;
  localparam int unsigned MIN_VALID    = 10;
  localparam logic [CNT_W-1:0] COUNT_CAP =
    CNT_W'((MAX_FEATURES < 2047) ? MAX_FEATURES : 2047);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Reset values of the configuration registers
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(179);
  localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(20);
  localparam logic [FOCAL_W-1:0] FOCAL_RST = FOCAL_W'(460);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN    = 2'd0,
    CFG_RATE    = 2'd1,
    CFG_FOCAL_U = 2'd2,
    CFG_FOCAL_V = 2'd3
  } cfg_idx_t;

  // Control and status between sequencer and root unit
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== sv/optical_flow_zero_motion_detect_unit.sv =====
// Top level of the optical-flow zero-motion detector: sequencer, state, config.
// Depends on ozmd_pkg, ozmd_mul (shared multiplier) and ozmd_sqrt (root unit).
//
// Usage:
//   Input: present one feature's flow (in_flow_x, in_flow_y, Q4.12), the
//   last-in-frame mark and the frame number, and raise start. The transaction
//   is taken at a clock edge with start high and busy low; busy then stays
//   high until the item is done.
//   A zero flow vector without the last mark leaves the block idle, busy low. A
//   nonzero vector is squared and added on the shared multiplier, then goes to
//   the square-root unit, which retires two radicand bits per cycle and hands
//   back the registered root. The last item of a frame adds three products on
//   the shared multiplier and one compare.
//   Output: on the last item of a frame, out_strobe is high for exactly one
//   cycle with out_is_still, out_valid_features and out_norm_total. The
//   receiver cannot stall; each result is taken in its strobe cycle.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes the addressed
//   register; write only while busy is low.
//   Reset (synchronous, rst_n low): sum and count clear, registers return to
//   gain 179, rate 20, focal lengths 460, and the block is idle.
module optical_flow_zero_motion_detect_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [ozmd_pkg::FLOW_W-1:0]  in_flow_x,
  input  logic signed [ozmd_pkg::FLOW_W-1:0]  in_flow_y,
  input  logic                           in_last_in_frame,
  input  logic [ozmd_pkg::FRAME_W-1:0]   in_frame_number,
  output logic                           out_strobe,
  output logic                           out_is_still,
  output logic [ozmd_pkg::CNT_W-1:0]     out_valid_features,
  output logic [ozmd_pkg::SUM_W-1:0]     out_norm_total,
  input  logic                           cfg_we,
  input  logic [ozmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ozmd_pkg::CFG_W-1:0]     cfg_wdata
);
  import ozmd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULY,
    ST_ADDSQ,
    ST_ROOT,
    ST_DEC_L,
    ST_DEC_G,
    ST_DEC_C,
    ST_DEC_R
  } state_t;

  state_t               state_r,   state_nxt;
  logic [FLOW_W-1:0]    ax_r,      ax_nxt;
  logic [FLOW_W-1:0]    ay_r,      ay_nxt;
  logic                 last_r,    last_nxt;
  logic                 fgt1_r,    fgt1_nxt;
  logic [SQ_W-1:0]      sq_r,      sq_nxt;
  logic [LHS_W-1:0]     lhs_r,     lhs_nxt;
  logic [SUM_W-1:0]     acc_r,     acc_nxt;
  logic [CNT_W-1:0]     cnt_r,     cnt_nxt;
  logic [GAIN_W-1:0]    gain_r,    gain_nxt;
  logic [RATE_W-1:0]    rate_r,    rate_nxt;
  logic [FOCAL_W-1:0]   fu_r,      fu_nxt;
  logic [FOCAL_W-1:0]   fv_r,      fv_nxt;
  logic                 strobe_r,  strobe_nxt;
  logic                 still_r,   still_nxt;
  logic [CNT_W-1:0]     ocnt_r,    ocnt_nxt;
  logic [SUM_W-1:0]     osum_r,    osum_nxt;

  logic                 accept;
  logic                 mul_en;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  sqrt_req_t            sq_req;
  sqrt_rsp_t            sq_rsp;
  logic [SUM_W:0]       acc_sum;
  logic [RHS_W-1:0]     rhs;
  logic                 still_dec;

  ozmd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  ozmd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Saturating norm sum and decision compare
  assign acc_sum   = (SUM_W+1)'(acc_r) + (SUM_W+1)'(sq_rsp.root);
  assign rhs       = {mul_p[RHS_W-5:0], 4'b0000};
  assign still_dec = (RHS_W'(lhs_r) < rhs) && fgt1_r
                     && (cnt_r > CNT_W'(MIN_VALID));

  // Select operands for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      ST_MULX: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(ax_r);
        mul_b  = ax_r;
      end
      ST_MULY: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(ay_r);
        mul_b  = ay_r;
      end
      ST_DEC_L: begin
        mul_en = 1'b1;
        mul_a  = acc_r;
        mul_b  = MUL_B_W'(FSUM_W'(fu_r) + FSUM_W'(fv_r));
      end
      ST_DEC_G: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(gain_r);
        mul_b  = MUL_B_W'(rate_r);
      end
      ST_DEC_C: begin
        mul_en = 1'b1;
        mul_a  = mul_p[GRATE_W-1:0];
        mul_b  = MUL_B_W'(cnt_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Sequence one transaction; write configuration
  always_comb begin
    state_nxt  = state_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    last_nxt   = last_r;
    fgt1_nxt   = fgt1_r;
    sq_nxt     = sq_r;
    lhs_nxt    = lhs_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    gain_nxt   = gain_r;
    rate_nxt   = rate_r;
    fu_nxt     = fu_r;
    fv_nxt     = fv_r;
    strobe_nxt = 1'b0;
    still_nxt  = still_r;
    ocnt_nxt   = ocnt_r;
    osum_nxt   = osum_r;
    sq_req.start    = 1'b0;
    sq_req.radicand = sq_r + SQ_W'(mul_p);

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN:    gain_nxt = cfg_wdata[GAIN_W-1:0];
        CFG_RATE:    rate_nxt = cfg_wdata[RATE_W-1:0];
        CFG_FOCAL_U: fu_nxt   = cfg_wdata[FOCAL_W-1:0];
        CFG_FOCAL_V: fv_nxt   = cfg_wdata[FOCAL_W-1:0];
        default:     gain_nxt = gain_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ax_nxt   = in_flow_x[FLOW_W-1] ? FLOW_W'(-in_flow_x) : in_flow_x;
          ay_nxt   = in_flow_y[FLOW_W-1] ? FLOW_W'(-in_flow_y) : in_flow_y;
          last_nxt = in_last_in_frame;
          fgt1_nxt = (in_frame_number > FRAME_W'(1));
          if ((in_flow_x != '0) || (in_flow_y != '0)) begin
            state_nxt = ST_MULX;
          end else if (in_last_in_frame) begin
            state_nxt = ST_DEC_L;
          end
        end
      end
      ST_MULX: begin
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        sq_nxt    = SQ_W'(mul_p);
        state_nxt = ST_ADDSQ;
      end
      ST_ADDSQ: begin
        sq_req.start = 1'b1;
        state_nxt    = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_rsp.done) begin
          acc_nxt = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
          if (cnt_r < COUNT_CAP) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = last_r ? ST_DEC_L : ST_IDLE;
        end
      end
      ST_DEC_L: begin
        state_nxt = ST_DEC_G;
      end
      ST_DEC_G: begin
        lhs_nxt   = mul_p[LHS_W-1:0];
        state_nxt = ST_DEC_C;
      end
      ST_DEC_C: begin
        state_nxt = ST_DEC_R;
      end
      ST_DEC_R: begin
        strobe_nxt = 1'b1;
        still_nxt  = still_dec;
        ocnt_nxt   = cnt_r;
        osum_nxt   = acc_r;
        acc_nxt    = '0;
        cnt_nxt    = '0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_r    <= '0;
      cnt_r    <= '0;
      gain_r   <= GAIN_RST;
      rate_r   <= RATE_RST;
      fu_r     <= FOCAL_RST;
      fv_r     <= FOCAL_RST;
      strobe_r <= 1'b0;
      still_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      gain_r   <= gain_nxt;
      rate_r   <= rate_nxt;
      fu_r     <= fu_nxt;
      fv_r     <= fv_nxt;
      strobe_r <= strobe_nxt;
      still_r  <= still_nxt;
    end
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    last_r <= last_nxt;
    fgt1_r <= fgt1_nxt;
    sq_r   <= sq_nxt;
    lhs_r  <= lhs_nxt;
    ocnt_r <= ocnt_nxt;
    osum_r <= osum_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_is_still       = still_r;
  assign out_valid_features = ocnt_r;
  assign out_norm_total     = osum_r;

  // At most one result per transaction
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in a row");

  // The frame totals are cleared once a result goes out
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((acc_r == '0) && (cnt_r == '0)))
    else $error("sum or count not cleared after result");

  // The feature count never passes its cap
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_CAP)
    else $error("valid count above cap");

  // The root unit only finishes while the sequencer waits for it
  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_rsp.done |-> (state_r == ST_ROOT))
    else $error("root finished outside its wait state");

endmodule

// ===== sv/ozmd_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on ozmd_pkg for operand and product widths.
module ozmd_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ozmd_pkg::MUL_A_W-1:0] op_a,
  input  logic [ozmd_pkg::MUL_B_W-1:0] op_b,
  output logic [ozmd_pkg::MUL_P_W-1:0] prod
);
  import ozmd_pkg::*;

  logic [MUL_P_W-1:0] prod_r;

  // Capture the product when the sequencer issues an operation
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

// ===== sv/ozmd_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on ozmd_pkg for widths and the request/response structs.
module ozmd_sqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ozmd_pkg::sqrt_req_t   req,
  output ozmd_pkg::sqrt_rsp_t   rsp
);
  import ozmd_pkg::*;

  logic                  run_r,  run_nxt;
  logic                  done_r, done_nxt;
  logic [ROOT_CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [SQ_W-1:0]       rad_r,  rad_nxt;
  logic [ROOT_W:0]       rem_r,  rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [ROOT_W+2:0]     cand;
  logic [ROOT_W+2:0]     trial;

  // Bring down two bits and try to subtract 4*root+1
  always_comb begin
    cand     = {rem_r, rad_r[SQ_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (req.start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = req.radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (run_r) begin
      rad_nxt = {rad_r[SQ_W-3:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (cand >= trial) begin
        rem_nxt  = (ROOT_W+1)'(cand - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = (ROOT_W+1)'(cand);
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      if (cnt_r == ROOT_CNT_W'(ROOT_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold iteration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

  // A finished root never coincides with a running iteration
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r)
    else $error("root done while still iterating");

  // A start always leads to a running iteration
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> run_r)
    else $error("root unit did not start");

  // The step count only advances while running
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!run_r && !req.start) |=> (cnt_r == $past(cnt_r)))
    else $error("root step count moved while idle");

endmodule

// ===== test/ozmd_flow_chk.sv =====
`timescale 1ns / 1ps
// Checker for the zero-motion detector: watches the feature, result and config ports.
// Predicts each frame verdict from accepted transactions; depends on ozmd_pkg.
module ozmd_flow_chk (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [ozmd_pkg::FLOW_W-1:0]  in_flow_x,
  input  logic signed [ozmd_pkg::FLOW_W-1:0]  in_flow_y,
  input  logic                                in_last_in_frame,
  input  logic [ozmd_pkg::FRAME_W-1:0]        in_frame_number,
  input  logic                                out_strobe,
  input  logic                                out_is_still,
  input  logic [ozmd_pkg::CNT_W-1:0]          out_valid_features,
  input  logic [ozmd_pkg::SUM_W-1:0]          out_norm_total,
  input  logic                                cfg_we,
  input  logic [ozmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ozmd_pkg::CFG_W-1:0]          cfg_wdata,
  output int                                  errors,
  output int                                  pending
);
  import ozmd_pkg::*;

  typedef struct packed {
    logic             is_still;
    logic [CNT_W-1:0] valid_features;
    logic [SUM_W-1:0] norm_total;
  } verdict_t;

  verdict_t verdict_q[$];

  // Predictor copy of the block state and registers
  logic [SUM_W-1:0]   norm_sum;
  logic [CNT_W-1:0]   feat_cnt;
  logic [GAIN_W-1:0]  gain;
  logic [RATE_W-1:0]  rate;
  logic [FOCAL_W-1:0] focal_u;
  logic [FOCAL_W-1:0] focal_v;
  int                 err_cnt = 0;

  assign errors = err_cnt;

  // Floor of the flow vector length, built one root bit at a time from the top
  function automatic logic [ROOT_W-1:0] flow_norm(input logic signed [FLOW_W-1:0] fx,
                                                  input logic signed [FLOW_W-1:0] fy);
    longint sq;
    longint trial;
    logic [ROOT_W-1:0] root;
    sq   = longint'(fx) * longint'(fx) + longint'(fy) * longint'(fy);
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = longint'(root | (ROOT_W'(1) << b));
      if (trial * trial <= sq) root = root | (ROOT_W'(1) << b);
    end
    return root;
  endfunction

  // Fold one feature into the frame state; return 1 with the verdict on the frame end
  function automatic bit predict_frame_verdict(input logic signed [FLOW_W-1:0] fx,
                                               input logic signed [FLOW_W-1:0] fy,
                                               input logic last,
                                               input logic [FRAME_W-1:0] frame,
                                               output verdict_t verdict);
    longint total;
    longint lhs;
    longint rhs;
    verdict = '0;
    if (fx != 0 || fy != 0) begin
      total    = longint'(norm_sum) + longint'(flow_norm(fx, fy));
      norm_sum = (total > longint'(SUM_MAX)) ? SUM_MAX : SUM_W'(total);
      if (feat_cnt < COUNT_CAP) feat_cnt = feat_cnt + 1'b1;
    end
    if (!last) return 1'b0;
    lhs = longint'(norm_sum) * (longint'(focal_u) + longint'(focal_v));
    rhs = longint'(gain) * longint'(rate) * longint'(feat_cnt) * 16;
    verdict.is_still       = (lhs < rhs) && (frame > 1) && (feat_cnt > MIN_VALID);
    verdict.valid_features = feat_cnt;
    verdict.norm_total     = norm_sum;
    norm_sum = '0;
    feat_cnt = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t seen;
    verdict_t want;
    if (!rst_n) begin
      // Return to the power-up state
      norm_sum = '0;
      feat_cnt = '0;
      gain     = GAIN_RST;
      rate     = RATE_RST;
      focal_u  = FOCAL_RST;
      focal_v  = FOCAL_RST;
      verdict_q.delete();
    end else begin
      // Compare each result transaction with the oldest prediction
      if (out_strobe) begin
        seen = '{out_is_still, out_valid_features, out_norm_total};
        if (verdict_q.size() == 0) begin
          $error("unexpected result: is_still %0d valid_features %0d norm_total %0d",
                 seen.is_still, seen.valid_features, seen.norm_total);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (seen.is_still !== want.is_still) begin
            $error("is_still mismatch: expected %0d, actual %0d",
                   want.is_still, seen.is_still);
            err_cnt++;
          end
          if (seen.valid_features !== want.valid_features) begin
            $error("valid_features mismatch: expected %0d, actual %0d",
                   want.valid_features, seen.valid_features);
            err_cnt++;
          end
          if (seen.norm_total !== want.norm_total) begin
            $error("norm_total mismatch: expected %0d, actual %0d",
                   want.norm_total, seen.norm_total);
            err_cnt++;
          end
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GAIN:    gain    = cfg_wdata[GAIN_W-1:0];
          CFG_RATE:    rate    = cfg_wdata[RATE_W-1:0];
          CFG_FOCAL_U: focal_u = cfg_wdata[FOCAL_W-1:0];
          CFG_FOCAL_V: focal_v = cfg_wdata[FOCAL_W-1:0];
          default: ;
        endcase
      end
      // Predict on each accepted feature transaction
      if (start && !busy) begin
        if (predict_frame_verdict(in_flow_x, in_flow_y, in_last_in_frame,
                                  in_frame_number, want))
          verdict_q.insert(verdict_q.size(), want);
      end
    end
    pending <= verdict_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the zero-motion detector: clock, reset, feature stimulus, verdict.
// Depends on ozmd_pkg, optical_flow_zero_motion_detect_unit and ozmd_flow_chk.
module tb_top;
  import ozmd_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [FLOW_W-1:0]  in_flow_x;
  logic signed [FLOW_W-1:0]  in_flow_y;
  logic                      in_last_in_frame;
  logic [FRAME_W-1:0]        in_frame_number;
  logic                      out_strobe;
  logic                      out_is_still;
  logic [CNT_W-1:0]          out_valid_features;
  logic [SUM_W-1:0]          out_norm_total;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;

  int check_errors;
  int verdicts_pending;
  int idle_pct;
  int still_level;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  optical_flow_zero_motion_detect_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_flow_x          (in_flow_x),
    .in_flow_y          (in_flow_y),
    .in_last_in_frame   (in_last_in_frame),
    .in_frame_number    (in_frame_number),
    .out_strobe         (out_strobe),
    .out_is_still       (out_is_still),
    .out_valid_features (out_valid_features),
    .out_norm_total     (out_norm_total),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  ozmd_flow_chk u_flow_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_flow_x          (in_flow_x),
    .in_flow_y          (in_flow_y),
    .in_last_in_frame   (in_last_in_frame),
    .in_frame_number    (in_frame_number),
    .out_strobe         (out_strobe),
    .out_is_still       (out_is_still),
    .out_valid_features (out_valid_features),
    .out_norm_total     (out_norm_total),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .errors             (check_errors),
    .pending            (verdicts_pending)
  );

  // Drop start for a random number of cycles, now and then for a long stretch
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    if (idle_pct > 0 && $urandom_range(49) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // Present one feature and hold it until the block takes the transaction
  task automatic send_feature(input logic signed [FLOW_W-1:0] fx,
                              input logic signed [FLOW_W-1:0] fy,
                              input logic last,
                              input logic [FRAME_W-1:0] frame);
    start            <= 1'b1;
    in_flow_x        <= fx;
    in_flow_y        <= fy;
    in_last_in_frame <= last;
    in_frame_number  <= frame;
    @(posedge clk);
    while (busy) @(posedge clk);
    idle_gap();
  endtask

  // Wait for every outstanding verdict, then let any work without a result finish
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write all four registers on back-to-back cycles
  task automatic write_settings(input logic [GAIN_W-1:0] gain,
                                input logic [RATE_W-1:0] rate,
                                input logic [FOCAL_W-1:0] fu,
                                input logic [FOCAL_W-1:0] fv);
    longint level;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_wdata <= CFG_W'(gain);
    @(posedge clk);
    cfg_index <= CFG_RATE;
    cfg_wdata <= CFG_W'(rate);
    @(posedge clk);
    cfg_index <= CFG_FOCAL_U;
    cfg_wdata <= CFG_W'(fu);
    @(posedge clk);
    cfg_index <= CFG_FOCAL_V;
    cfg_wdata <= CFG_W'(fv);
    @(posedge clk);
    cfg_we <= 1'b0;
    // Mean norm at which a frame flips between still and moving
    level = (longint'(gain) * longint'(rate) * 16) / (longint'(fu) + longint'(fv));
    still_level = (level > 32767) ? 32767 : ((level < 1) ? 1 : int'(level));
  endtask

  function automatic logic signed [FLOW_W-1:0] rand_comp(input int lim);
    return FLOW_W'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // Random frames: mostly short, some near the minimum valid count, some long
  task automatic random_frames(input int n_items);
    int sent;
    int nfeat;
    int lim;
    int zero_pct;
    int motion;
    logic [FRAME_W-1:0] frame;
    logic signed [FLOW_W-1:0] fx;
    logic signed [FLOW_W-1:0] fy;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9)) inside
        [0:5]:   nfeat = $urandom_range(1, 20);
        [6:7]:   nfeat = $urandom_range(9, 13);
        8:       nfeat = $urandom_range(20, 60);
        default: nfeat = 1;
      endcase
      motion   = $urandom_range(3);
      lim      = (motion == 0) ? still_level / 3 + 1 : still_level;
      zero_pct = ($urandom_range(3) == 0) ? 40 : 8;
      frame    = ($urandom_range(4) == 0) ? FRAME_W'($urandom_range(0, 2)) : FRAME_W'($urandom);
      for (int i = 0; i < nfeat; i++) begin
        if ($urandom_range(99) < zero_pct) begin
          fx = '0;
          fy = '0;
        end else if (motion == 3) begin
          fx = FLOW_W'($urandom);
          fy = FLOW_W'($urandom);
        end else begin
          fx = rand_comp(lim);
          fy = rand_comp(lim);
        end
        send_feature(fx, fy, i == nfeat - 1, frame);
      end
      sent += nfeat;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_flow_x        = '0;
    in_flow_y        = '0;
    in_last_in_frame = 1'b0;
    in_frame_number  = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_GAIN;
    cfg_wdata        = '0;
    idle_pct         = 0;
    still_level      = 62;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero flow, an empty frame, extreme vectors on frame zero
    send_feature(16'sd0, 16'sd0, 1'b0, 16'd3);
    send_feature(16'sd0, 16'sd0, 1'b1, 16'd3);
    send_feature(-16'sd32768, -16'sd32768, 1'b0, 16'd0);
    send_feature(16'sd32767, -16'sd32768, 1'b0, 16'd0);
    send_feature(16'sd0, -16'sd1, 1'b0, 16'd0);
    send_feature(16'sd1, 16'sd0, 1'b1, 16'd0);
    // Directed: eleven slow features on frame two, a still frame at reset settings
    for (int i = 0; i < 11; i++)
      send_feature(FLOW_W'(i + 1), -FLOW_W'(i), i == 10, 16'hFFFF - 16'(i == 10) * 16'hFFFD);
    drain();

    // No idling; widest threshold, then one frame that saturates the count
    write_settings(16'hFFFF, 10'd1000, 13'd1, 13'd1);
    for (int i = 0; i < 1030; i++)
      send_feature(-16'sd32768, -16'sd32768, i == 1029, 16'd9);
    random_frames(140);
    drain();

    // Sender mostly idle; zero gain, nothing can be still
    idle_pct = 82;
    write_settings(16'h0000, 10'd1, 13'd8191, 13'd8191);
    random_frames(140);
    drain();

    // Light idling; moderate settings
    idle_pct = 13;
    write_settings(GAIN_W'($urandom_range(64, 1024)), RATE_W'($urandom_range(10, 120)),
                   FOCAL_W'($urandom_range(200, 2000)), FOCAL_W'($urandom_range(200, 2000)));
    random_frames(140);
    drain();

    // No idling; fully random settings
    idle_pct = 0;
    write_settings(GAIN_W'($urandom), RATE_W'($urandom_range(1, 1000)),
                   FOCAL_W'($urandom_range(1, 8191)), FOCAL_W'($urandom_range(1, 8191)));
    random_frames(140);
    drain();

    if (check_errors == 0 && verdicts_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ozmd_pkg.sv
sv/ozmd_mul.sv
sv/ozmd_sqrt.sv
sv/optical_flow_zero_motion_detect_unit.sv
test/ozmd_flow_chk.sv
test/tb_top.sv
